// ===== design/set_assoc_cache_fifo_assert.svh =====
// ---------------------------------------------------------------------------
// set_assoc_cache_fifo_assert.svh
// Assertion macros used by the cache model RTL.
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_FIFO_ASSERT_SVH
`define SET_ASSOC_CACHE_FIFO_ASSERT_SVH

// same-cycle implication
`define SACF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SACF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sacf_pkg.sv =====
// ---------------------------------------------------------------------------
// sacf_pkg
// Shared constants, types and helpers of the set-associative cache model.
// ---------------------------------------------------------------------------
package sacf_pkg;

  localparam int SETS_LOG2_DEF = 6;
  localparam int WAYS_DEF      = 8;
  localparam int ADDR_W        = 64;
  localparam int CNT_W         = 32;
  localparam int WAYS_CNT_W    = 5;   // holds 0..31
  localparam int CFG_DATA_W    = 6;
  localparam int CFG_IDX_W     = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 2'd2;

  // reset values of the registers
  localparam logic [2:0] SET_INDEX_BITS_RST = 3'd4;
  localparam logic [5:0] OFFSET_BITS_RST    = 6'd4;
  localparam logic [3:0] WAYS_IN_USE_RST    = 4'd1;

  // access kinds; load, store and the unused code all behave as a load
  localparam logic [1:0] REQ_MODIFY = 2'd2;

  typedef struct packed {
    logic hit;
    logic evict;
  } sacf_status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ===== design/sacf_set_ram.sv =====
// ---------------------------------------------------------------------------
// sacf_set_ram
// One row per set: tags, valid bits and round-robin pointer. Registered read.
// ---------------------------------------------------------------------------
module sacf_set_ram #(
  parameter int ADDR_BITS = 6,
  parameter int DEPTH     = 64,
  parameter int ROW_W     = 8
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [ROW_W-1:0]     rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [ROW_W-1:0]     wr_data
);

  logic [ROW_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/sacf_set_update.sv =====
// ---------------------------------------------------------------------------
// sacf_set_update
// Tag compare over one set and the replacement decision; builds the new row.
// ---------------------------------------------------------------------------
module sacf_set_update #(
  parameter int WAYS = 8,
  parameter int PW   = 3
) (
  input  logic [WAYS-1:0][sacf_pkg::ADDR_W-1:0] row_tag,
  input  logic [WAYS-1:0]                       row_valid,
  input  logic [PW-1:0]                         row_ptr,
  input  logic [sacf_pkg::ADDR_W-1:0]           tag,
  input  logic [sacf_pkg::WAYS_CNT_W-1:0]       ways_eff,
  output logic [WAYS-1:0][sacf_pkg::ADDR_W-1:0] new_tag,
  output logic [WAYS-1:0]                       new_valid,
  output logic [PW-1:0]                         new_ptr,
  output sacf_pkg::sacf_status_t                status
);

  logic                            hit;
  logic                            free_found;
  logic [PW-1:0]                   free_way;
  logic [sacf_pkg::WAYS_CNT_W-1:0] ptr_ext;
  logic [sacf_pkg::WAYS_CNT_W-1:0] victim;
  logic [sacf_pkg::WAYS_CNT_W-1:0] victim_inc;

  // lookup over the ways in use; lowest invalid way is the fill target
  always_comb begin
    hit        = 1'b0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (sacf_pkg::WAYS_CNT_W'(w) < ways_eff) begin
        if (row_valid[w]) begin
          if (row_tag[w] == tag) begin
            hit = 1'b1;
          end
        end else if (!free_found) begin
          free_found = 1'b1;
          free_way   = PW'(w);
        end
      end
    end
  end

  // a pointer left beyond the ways in use falls back to way 0
  assign ptr_ext    = sacf_pkg::WAYS_CNT_W'(row_ptr);
  assign victim     = (ptr_ext >= ways_eff) ? '0 : ptr_ext;
  assign victim_inc = victim + 1'b1;

  always_comb begin
    new_tag      = row_tag;
    new_valid    = row_valid;
    new_ptr      = row_ptr;
    status.hit   = hit;
    status.evict = 1'b0;
    if (!hit) begin
      if (free_found) begin
        new_valid[free_way] = 1'b1;
        new_tag[free_way]   = tag;
      end else begin
        new_tag[victim[PW-1:0]] = tag;
        new_ptr      = (victim_inc == ways_eff) ? '0 : victim_inc[PW-1:0];
        status.evict = 1'b1;
      end
    end
  end

endmodule

// ===== design/set_assoc_cache_fifo.sv =====
// Flow: an accepted item is read from the set memory, then compared and written back in
//   ST_UPDATE, where its result is registered onto m_tdata; a stalled result holds the write back.
// No new item is taken until the last one is written back, due to the read-modify-write of
//   one set row in the set memory (read on accept, compare and write back in ST_UPDATE).
// Reset: synchronous; counters, registers and handshake state clear at once, then a
//   clearing pass writes every set row with s_tready low.
//   Configuration writes are taken during the pass.
// ---------------------------------------------------------------------------
// set_assoc_cache_fifo
// Hit/miss model of a set-associative cache with per-set round-robin
// replacement and saturating hit, miss and eviction counters.
// ---------------------------------------------------------------------------
`include "set_assoc_cache_fifo_assert.svh"

module set_assoc_cache_fifo #(
  parameter int SETS_LOG2 = sacf_pkg::SETS_LOG2_DEF,
  parameter int WAYS      = sacf_pkg::WAYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sacf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sacf_pkg::CFG_DATA_W-1:0]  cfg_data,
  // access items
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [71:0]                      s_tdata,  // req_type[1:0], address[65:2], zero pad
  // result items
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [103:0]                     m_tdata   // was_hit[0], was_miss[1], did_evict[2],
                                                     // hit_total[34:3], miss_total[66:35],
                                                     // evict_total[98:67], zero pad
);

  localparam int ADDR_W  = sacf_pkg::ADDR_W;
  localparam int CNT_W   = sacf_pkg::CNT_W;
  localparam int WCW     = sacf_pkg::WAYS_CNT_W;
  localparam int NSETS   = 1 << SETS_LOG2;
  localparam int ROW_AW  = (SETS_LOG2 > 0) ? SETS_LOG2 : 1;
  localparam int PW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_BITS = WAYS * ADDR_W;
  localparam int ROW_W   = TAG_BITS + WAYS + PW;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  state_t state;

  // configuration registers
  logic [2:0] set_index_bits;
  logic [5:0] offset_bits;
  logic [3:0] ways_in_use;

  // counters
  logic [CNT_W-1:0] hit_cnt;
  logic [CNT_W-1:0] miss_cnt;
  logic [CNT_W-1:0] evict_cnt;

  // request held across the read
  logic [1:0]        req_kind;
  logic [ADDR_W-1:0] req_tag;
  logic [ROW_AW-1:0] req_set;

  logic [ROW_AW-1:0] clr_idx;

  // address split
  logic [ADDR_W-1:0] blk;
  logic [3:0]        sbits;
  logic [ROW_AW-1:0] set_mask;
  logic [ROW_AW-1:0] in_set;
  logic [ADDR_W-1:0] in_tag;
  logic              in_fire;

  // set row
  logic [ROW_W-1:0]             rd_row;
  logic [ROW_W-1:0]             wr_row;
  logic                         wr_en;
  logic [ROW_AW-1:0]            wr_addr;
  logic [WAYS-1:0][ADDR_W-1:0]  row_tag;
  logic [WAYS-1:0]              row_valid;
  logic [PW-1:0]                row_ptr;
  logic [WAYS-1:0][ADDR_W-1:0]  new_tag;
  logic [WAYS-1:0]              new_valid;
  logic [PW-1:0]                new_ptr;
  sacf_pkg::sacf_status_t       status;
  logic [WCW-1:0]               ways_eff;
  logic                         upd_fire;

  logic [CNT_W-1:0] hit_step;
  logic [CNT_W-1:0] hit_next;
  logic [CNT_W-1:0] miss_next;
  logic [CNT_W-1:0] evict_next;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;

  // block number, set and tag of the incoming address; offset never reaches 64
  assign blk      = s_tdata[65:2] >> offset_bits;
  assign sbits    = ({1'b0, set_index_bits} > 4'(SETS_LOG2)) ? 4'(SETS_LOG2)
                                                             : {1'b0, set_index_bits};
  assign set_mask = ~({ROW_AW{1'b1}} << sbits);
  assign in_set   = blk[ROW_AW-1:0] & set_mask;
  assign in_tag   = blk >> sbits;

  // ways in use clamped to 1..WAYS
  always_comb begin
    if (ways_in_use == '0) begin
      ways_eff = WCW'(1);
    end else if (WCW'(ways_in_use) > WCW'(WAYS)) begin
      ways_eff = WCW'(WAYS);
    end else begin
      ways_eff = WCW'(ways_in_use);
    end
  end

  assign row_tag   = rd_row[TAG_BITS-1:0];
  assign row_valid = rd_row[TAG_BITS +: WAYS];
  assign row_ptr   = rd_row[TAG_BITS + WAYS +: PW];

  // write back only once the output register is free to take the result
  assign upd_fire = (state == ST_UPDATE) && (!m_tvalid || m_tready);
  assign wr_en    = (state == ST_CLEAR) || upd_fire;
  assign wr_addr  = (state == ST_CLEAR) ? clr_idx : req_set;
  assign wr_row   = (state == ST_CLEAR) ? '0 : {new_ptr, new_valid, new_tag};

  sacf_set_ram #(
    .ADDR_BITS (ROW_AW),
    .DEPTH     (NSETS),
    .ROW_W     (ROW_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (in_set),
    .rd_data (rd_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row)
  );

  sacf_set_update #(
    .WAYS (WAYS),
    .PW   (PW)
  ) u_update (
    .row_tag   (row_tag),
    .row_valid (row_valid),
    .row_ptr   (row_ptr),
    .tag       (req_tag),
    .ways_eff  (ways_eff),
    .new_tag   (new_tag),
    .new_valid (new_valid),
    .new_ptr   (new_ptr),
    .status    (status)
  );

  // modify adds an extra always-hit store on top of the lookup
  assign hit_step   = status.hit ? sacf_pkg::sat_inc(hit_cnt) : hit_cnt;
  assign hit_next   = (req_kind == sacf_pkg::REQ_MODIFY) ? sacf_pkg::sat_inc(hit_step)
                                                          : hit_step;
  assign miss_next  = status.hit ? miss_cnt : sacf_pkg::sat_inc(miss_cnt);
  assign evict_next = status.evict ? sacf_pkg::sat_inc(evict_cnt) : evict_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_idx        <= '0;
      m_tvalid       <= 1'b0;
      hit_cnt        <= '0;
      miss_cnt       <= '0;
      evict_cnt      <= '0;
      set_index_bits <= sacf_pkg::SET_INDEX_BITS_RST;
      offset_bits    <= sacf_pkg::OFFSET_BITS_RST;
      ways_in_use    <= sacf_pkg::WAYS_IN_USE_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sacf_pkg::CFG_SET_INDEX_BITS: set_index_bits <= cfg_data[2:0];
          sacf_pkg::CFG_OFFSET_BITS:    offset_bits    <= cfg_data[5:0];
          sacf_pkg::CFG_WAYS_IN_USE:    ways_in_use    <= cfg_data[3:0];
          default: ;
        endcase
      end

      // a write back in the same cycle sets it again below
      if (m_tvalid && m_tready && !upd_fire) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          if (clr_idx == ROW_AW'(NSETS - 1)) begin
            state <= ST_IDLE;
          end
          clr_idx <= clr_idx + 1'b1;
        end
        ST_IDLE: begin
          if (in_fire) begin
            req_kind <= s_tdata[1:0];
            req_tag  <= in_tag;
            req_set  <= in_set;
            state    <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (upd_fire) begin
            hit_cnt   <= hit_next;
            miss_cnt  <= miss_next;
            evict_cnt <= evict_next;
            m_tvalid  <= 1'b1;
            m_tdata   <= {5'b0, evict_next, miss_next, hit_next,
                          status.evict, !status.hit, status.hit};
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a result is either a hit or a miss, never both
  `SACF_ASSERT_NOW(a_hit_xor_miss, clk, rst, m_tvalid, m_tdata[0] ^ m_tdata[1], "hit and miss flags disagree")
  // replacement happens only on a miss
  `SACF_ASSERT_NOW(a_evict_on_miss, clk, rst, m_tvalid && m_tdata[2], m_tdata[1], "eviction without a miss")
  // evictions are a subset of misses
  `SACF_ASSERT_NOW(a_evict_le_miss, clk, rst, 1'b1, evict_cnt <= miss_cnt, "eviction count exceeds miss count")
  // a write back always presents its result in the next cycle
  `SACF_ASSERT_NEXT(a_result_after_update, clk, rst, upd_fire, m_tvalid && state == ST_IDLE, "result not presented after write back")

endmodule
